FILE: hw/rtl/sequence_symbol_bit_packer_defines.svh
// ----------------------------------------------------------------------------
// sequence_symbol_bit_packer_defines.svh
// Assertion macros shared by the packer checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_SYMBOL_BIT_PACKER_DEFINES_SVH
`define SEQUENCE_SYMBOL_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssbp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssbp: next-cycle check failed");

`endif

FILE: hw/rtl/ssbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_pkg
// Types, register indexes and translation tables for the symbol bit packer.
// ----------------------------------------------------------------------------
package ssbp_pkg;

	localparam int CNT_W  = 4;

	// Result queue depth; a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic REG_ALPHABET_MODE = 1'b0;
	localparam logic REG_SYM_BITS      = 1'b1;

	localparam logic [CNT_W-1:0] FULL_BYTE = 4'd8;

	typedef struct packed {
		logic [7:0] seq_char;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic [3:0] valid_bits;
		logic       last_byte;
	} out_word_t;

	// Result of packing one character: up to two words, in order
	typedef struct packed {
		logic [1:0] num;
		out_word_t  res0;
		out_word_t  res1;
		logic [2:0] next_offset;
		logic [7:0] next_partial;
	} pack_res_t;

	localparam logic [4:0] DNA_CODES [26] = '{
		5'd0, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0, 5'd2, 5'd0, 5'd0, 5'd0, 5'd2, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd2, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0
	};

	localparam logic [4:0] PROTEIN_CODES [26] = '{
		5'd0, 5'd0, 5'd4, 5'd3, 5'd6, 5'd13, 5'd7, 5'd8, 5'd9, 5'd0, 5'd11, 5'd10, 5'd12,
		5'd2, 5'd0, 5'd14, 5'd5, 5'd1, 5'd15, 5'd16, 5'd0, 5'd19, 5'd17, 5'd0, 5'd18, 5'd0
	};

	// Letter to symbol code; anything that is not a letter gives zero
	function automatic logic [7:0] symbol_code(input logic [7:0] ch, input logic mode);
		logic [7:0] idx8;
		logic [4:0] idx;
		logic       is_letter;
		idx8      = 8'd0;
		is_letter = 1'b0;
		if (ch >= 8'd65 && ch <= 8'd90) begin
			idx8      = ch - 8'd65;
			is_letter = 1'b1;
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			idx8      = ch - 8'd97;
			is_letter = 1'b1;
		end
		idx = idx8[4:0];
		if (!is_letter) begin
			return 8'd0;
		end
		return mode ? {3'b000, PROTEIN_CODES[idx]} : {3'b000, DNA_CODES[idx]};
	endfunction

	// Clamp the bit count to 1..8
	function automatic logic [CNT_W-1:0] eff_bits(input logic [CNT_W-1:0] bits);
		if (bits == '0) begin
			return 4'd1;
		end
		if (bits > FULL_BYTE) begin
			return FULL_BYTE;
		end
		return bits;
	endfunction

endpackage

FILE: hw/rtl/ssbp_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_pack
// Translate one character and merge its code into the partial byte.
// ----------------------------------------------------------------------------
module ssbp_pack
	import ssbp_pkg::*;
(
	input  logic       alphabet_mode,
	input  logic [3:0] sym_bits,
	input  logic [2:0] bit_offset,
	input  logic [7:0] partial_byte,
	input  in_word_t   item,
	output pack_res_t  res
);

	logic [3:0]  bits;
	logic [7:0]  mask;
	logic [7:0]  code;
	logic [3:0]  total;
	logic [3:0]  sh;
	logic [15:0] acc;
	logic        full;
	logic [15:0] acc2;
	logic [3:0]  tot2;
	logic        flush;
	out_word_t   first_w;
	out_word_t   flush_w;

	always_comb begin
		bits  = eff_bits(sym_bits);
		mask  = 8'hFF >> (FULL_BYTE - bits);
		code  = symbol_code(item.seq_char, alphabet_mode) & mask;
		total = {1'b0, bit_offset} + bits;
		sh    = 4'(5'd16 - {1'b0, total});
		acc   = {partial_byte, 8'h00} | ({8'h00, code} << sh);
		full  = (total >= FULL_BYTE);
		acc2  = full ? {acc[7:0], 8'h00} : acc;
		tot2  = full ? (total - FULL_BYTE) : total;
		flush = item.is_last && (tot2 != '0);

		first_w.packed_byte = acc[15:8];
		first_w.valid_bits  = FULL_BYTE;
		first_w.last_byte   = item.is_last && (tot2 == '0);

		flush_w.packed_byte = acc2[15:8];
		flush_w.valid_bits  = tot2;
		flush_w.last_byte   = 1'b1;

		if (full) begin
			res.res0 = first_w;
			res.res1 = flush_w;
			res.num  = flush ? 2'd2 : 2'd1;
		end else begin
			res.res0 = flush_w;
			res.res1 = flush_w;
			res.num  = flush ? 2'd1 : 2'd0;
		end

		if (item.is_last) begin
			res.next_offset  = 3'd0;
			res.next_partial = 8'd0;
		end else begin
			res.next_offset  = tot2[2:0];
			res.next_partial = acc2[15:8];
		end
	end

endmodule

FILE: hw/rtl/sequence_symbol_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_symbol_bit_packer
// Map sequence characters to symbol codes and pack them MSB-first into bytes.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input stage until the result queue has
//   room, then its bytes are written to the queue, whose head drives out_word.
// Throughput: one character per cycle while the queue has room for two bytes;
//   a character that yields two bytes is absorbed by the four-entry result queue.
// Reset: arst_n clears the queue, the stage valid, the packing state and
//   the registers (protein off, two bits per symbol).
// ----------------------------------------------------------------------------
module sequence_symbol_bit_packer
	import ssbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// character stream
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	// packed byte stream
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word,
	// configuration writes
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic       alphabet_mode_q;
	logic [3:0] sym_bits_q;

	// packing state carried between characters
	logic [2:0] bit_offset_q;
	logic [7:0] partial_byte_q;

	// input stage
	logic       valid_s1;
	in_word_t   word_s1;

	// result queue
	out_word_t          queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	pack_res_t          pack_res;
	logic               room;
	logic               advance;
	logic               in_take;
	logic               out_take;
	logic [CNT_QW-1:0]  push_n;
	logic [PTR_W-1:0]   wr_ptr_nx;

	// Pack the staged character against the current state
	ssbp_pack u_pack (
		.alphabet_mode (alphabet_mode_q),
		.sym_bits      (sym_bits_q),
		.bit_offset    (bit_offset_q),
		.partial_byte  (partial_byte_q),
		.item          (word_s1),
		.res           (pack_res)
	);

	// The stage may hand on its character only while the queue can take
	// the worst case of two bytes.
	assign room      = (count_q <= CNT_QW'(QUEUE_DEPTH - 2));
	assign advance   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign out_word  = queue_q[rd_ptr_q];
	assign out_take  = out_valid && !out_stall;
	assign push_n    = advance ? CNT_QW'(pack_res.num) : '0;
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	// Configuration: the user must write it only while idle, so no hazard with the stage; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_mode_q <= 1'b0;
			sym_bits_q      <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHABET_MODE: alphabet_mode_q <= cfg_data[0];
				REG_SYM_BITS:      sym_bits_q      <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Input stage control; hold the character while the queue is short of room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_word;
		end
	end

	// Advance the packing state as each character is retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_offset_q   <= '0;
			partial_byte_q <= '0;
		end else if (advance) begin
			bit_offset_q   <= pack_res.next_offset;
			partial_byte_q <= pack_res.next_partial;
		end
	end

	// Queue payload: write zero, one or two bytes at the tail
	always_ff @(posedge clk) begin
		if (advance && pack_res.num != 2'd0) begin
			queue_q[wr_ptr_q] <= pack_res.res0;
		end
		if (advance && pack_res.num == 2'd2) begin
			queue_q[wr_ptr_nx] <= pack_res.res1;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + push_n - CNT_QW'(out_take);
		end
	end

endmodule

FILE: hw/rtl/ssbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbp_checker
// Port-level checks on the packed byte stream of the symbol bit packer.
// ----------------------------------------------------------------------------
`include "sequence_symbol_bit_packer_defines.svh"

module ssbp_checker
	import ssbp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	// hold a stalled byte
	`SSBP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// only the final byte of a sequence may be short
	`SSBP_ASSERT_NOW(a_full_unless_last, clk, arst_n, out_valid && !out_word.last_byte, out_word.valid_bits == FULL_BYTE)

	// bit count stays within one byte and is never empty
	`SSBP_ASSERT_NOW(a_bits_range, clk, arst_n, out_valid, out_word.valid_bits != 4'd0 && out_word.valid_bits <= FULL_BYTE)

endmodule

bind sequence_symbol_bit_packer ssbp_checker u_ssbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

FILE: tb/tb_sequence_symbol_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_symbol_bit_packer
// Self-checking bench for the sequence symbol bit packer. Sequence characters
// are pushed through the input handshake under random gaps. A scoreboard
// predicts the packed bytes from its own translation tables and packing state,
// and checks every byte taken from the output side, which stalls at random.
// The registers are rewritten between phases while the block is idle, across
// both alphabets and bit counts from the out-of-range low end to the high end.
// ----------------------------------------------------------------------------
module tb_sequence_symbol_bit_packer;
	import ssbp_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_WORDS   = 125;
	localparam int NUM_PHASES    = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_PRINTED   = 100;

	// Predicts the packed byte stream and checks it word by word
	class packer_scoreboard;
		logic       mode;
		logic [3:0] bits;
		logic [2:0] offset;
		logic [7:0] partial;
		out_word_t  expected_bytes[$];
		int         errors;

		function new();
			mode    = 1'b0;
			bits    = 4'd2;
			offset  = 3'd0;
			partial = 8'd0;
			errors  = 0;
		endfunction

		function void write_reg(input logic idx, input logic [3:0] value);
			if (idx == REG_ALPHABET_MODE) begin
				mode = value[0];
			end else begin
				bits = value;
			end
		endfunction

		// Translate a character; case folds, non-letters give zero
		function logic [7:0] letter_code(input logic [7:0] ch);
			logic [7:0] up;
			up = (ch >= 8'd97 && ch <= 8'd122) ? ch - 8'd32 : ch;
			if (!mode) begin
				case (up)
					"C", "B", "Y": return 8'd1;
					"G", "S", "K": return 8'd2;
					"T":           return 8'd3;
					default:       return 8'd0;
				endcase
			end
			case (up)
				"R": return 8'd1;
				"N": return 8'd2;
				"D": return 8'd3;
				"C": return 8'd4;
				"Q": return 8'd5;
				"E": return 8'd6;
				"G": return 8'd7;
				"H": return 8'd8;
				"I": return 8'd9;
				"L": return 8'd10;
				"K": return 8'd11;
				"M": return 8'd12;
				"F": return 8'd13;
				"P": return 8'd14;
				"S": return 8'd15;
				"T": return 8'd16;
				"W": return 8'd17;
				"Y": return 8'd18;
				"V": return 8'd19;
				default: return 8'd0;
			endcase
		endfunction

		// Pack one accepted character and queue the bytes it completes
		function void note_char(input in_word_t w);
			logic [3:0]  nbits;
			logic [7:0]  mask;
			logic [7:0]  code;
			logic [4:0]  total;
			logic [15:0] acc;
			out_word_t   e;
			nbits = (bits == 4'd0) ? 4'd1 : ((bits > 4'd8) ? 4'd8 : bits);
			mask  = 8'((9'h1 << nbits) - 9'h1);
			code  = letter_code(w.seq_char) & mask;
			total = 5'(offset) + 5'(nbits);
			acc   = {partial, 8'h00} | ({8'h00, code} << (16 - total));
			if (total >= 5'd8) begin
				e.packed_byte = acc[15:8];
				e.valid_bits  = 4'd8;
				e.last_byte   = w.is_last && (total == 5'd8);
				expected_bytes.insert(expected_bytes.size(), e);
				acc   = acc << 8;
				total = total - 5'd8;
			end
			if (w.is_last) begin
				// flush the remainder, zero-padded, and start a fresh sequence
				if (total != 5'd0) begin
					e.packed_byte = acc[15:8];
					e.valid_bits  = total[3:0];
					e.last_byte   = 1'b1;
					expected_bytes.insert(expected_bytes.size(), e);
				end
				offset  = 3'd0;
				partial = 8'd0;
			end else begin
				offset  = total[2:0];
				partial = acc[15:8];
			end
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_PRINTED) begin
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			end
		endtask

		task check_byte(input out_word_t got);
			out_word_t e;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h", got.packed_byte));
				return;
			end
			e = expected_bytes.pop_front();
			if (got.packed_byte !== e.packed_byte)
				report($sformatf("packed_byte %02h, want %02h", got.packed_byte,
					e.packed_byte));
			if (got.valid_bits !== e.valid_bits)
				report($sformatf("valid_bits %0d, want %0d", got.valid_bits, e.valid_bits));
			if (got.last_byte !== e.last_byte)
				report($sformatf("last_byte %0b, want %0b", got.last_byte, e.last_byte));
		endtask
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_word_t   in_word   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic [3:0] cfg_data  = 4'd0;

	packer_scoreboard packer_sb = new();
	int          in_gap_max    = 10;
	int          out_stall_max = 10;
	int unsigned cycle_count   = 0;

	sequence_symbol_bit_packer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Watchdog: drop out if the stream hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Check every byte taken from the output side. Values read here are
	// those in force at the edge, since everything updates by nonblocking
	// assignment.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			packer_sb.check_byte(out_word);
		end
	end

	// Output side: before each word hold stall for a random number of
	// cycles, then release it until a word is taken
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = $urandom_range(0, out_stall_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Present one word after a random gap and hold it until it is taken
	task send_char(input in_word_t w);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		packer_sb.note_char(w);
	endtask

	task send_text(input string s, input logic end_seq);
		in_word_t w;
		for (int i = 0; i < s.len(); i++) begin
			w.seq_char = s[i];
			w.is_last  = end_seq && (i == s.len() - 1);
			send_char(w);
		end
	endtask

	// Let every queued byte come out, then give the pipeline time to settle
	// any character that made no byte
	task drain_packer();
		in_valid <= 1'b0;
		while (packer_sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_config(input logic mode, input logic [3:0] nbits);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ALPHABET_MODE;
		cfg_data  <= {3'b000, mode};
		@(posedge clk);
		packer_sb.write_reg(REG_ALPHABET_MODE, {3'b000, mode});
		cfg_index <= REG_SYM_BITS;
		cfg_data  <= nbits;
		@(posedge clk);
		packer_sb.write_reg(REG_SYM_BITS, nbits);
		cfg_we <= 1'b0;
	endtask

	// Mostly table letters in random case, then any letter, then any byte
	function automatic logic [7:0] pick_char(input logic mode);
		string      letters;
		logic [7:0] ch;
		int         r;
		if (mode)
			letters = "ARNDCQEGHILKMFPSTWYV";
		else
			letters = "CBYGSKT";
		r = $urandom_range(0, 99);
		if (r < 70) begin
			ch = letters[$urandom_range(0, letters.len() - 1)];
			if ($urandom_range(0, 1)) ch = ch + 8'd32;
		end else if (r < 85) begin
			ch = 8'd65 + 8'($urandom_range(0, 25));
			if ($urandom_range(0, 1)) ch = ch + 8'd32;
		end else begin
			ch = 8'($urandom_range(0, 255));
		end
		return ch;
	endfunction

	logic       phase_mode [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	// out-of-range counts sit among the legal ones: zero, nine and fifteen
	logic [3:0] phase_bits [NUM_PHASES] = '{4'd5, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3,
		4'd7, 4'd9, 4'd4, 4'd6, 4'd2, 4'd8};
	logic [7:0] odd_chars [8] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B,
		8'h5A, 8'h41};

	initial begin
		in_word_t w;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words on the reset settings: DNA, two bits per symbol
		send_text("ACGT", 1'b1);    // exactly one full byte, marked last
		send_text("cgt", 1'b1);     // partial flush, zero-padded
		send_text("BYSK", 1'b0);
		send_text("bysk", 1'b1);
		// Non-letters and the letter range edges, ending the sequence
		foreach (odd_chars[i]) begin
			w.seq_char = odd_chars[i];
			w.is_last  = (i == 7);
			send_char(w);
		end
		drain_packer();

		// Random phases; a phase often ends mid-sequence, so the packing
		// state carries across a register write
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_config(phase_mode[p], phase_bits[p]);
			in_gap_max    = (p % 3 == 0) ? 0 : 10;
			out_stall_max = (p % 4 == 1) ? 0 : 10;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				w.seq_char = pick_char(phase_mode[p]);
				w.is_last  = ($urandom_range(0, 7) == 0);
				send_char(w);
			end
			drain_packer();
		end

		if (packer_sb.expected_bytes.size() != 0)
			packer_sb.report("bytes still expected at the end");
		if (packer_sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ssbp_pkg.sv
hw/rtl/ssbp_pack.sv
hw/rtl/sequence_symbol_bit_packer.sv
hw/rtl/ssbp_checker.sv
tb/tb_sequence_symbol_bit_packer.sv
